// ----- hw/rtl/pve_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pve_pkg
// Shared types and constants of the posting varint encoder.
// ----------------------------------------------------------------------------
package pve_pkg;

    localparam int ACTION_W   = 2;
    localparam int POS_W      = 36;
    localparam int STYLE_W    = 2;
    localparam int DOC_W      = 8;
    localparam int IN_DATA_W  = 48;

    localparam int WORD_W     = POS_W + DOC_W;   // widest code word
    localparam int ENC_W      = 56;
    localparam int LEN_W      = 3;
    localparam int OUT_DATA_W = 64;

    localparam int GROUP_BITS     = 6;
    localparam int GROUPS         = POS_W / GROUP_BITS;
    localparam int SPREAD_W       = 8 * GROUPS;
    localparam int ONE_BYTE_LIMIT = 7;
    localparam int EXTRA_STEP     = 5;
    localparam int MAX_EXTRA      = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BODY  = 2'd0,
        ACT_TITLE = 2'd1,
        ACT_EOD   = 2'd2,
        ACT_EOD_X = 2'd3
    } t_action;

    // Result of the layout stage: data bits placed in groups with the
    // continuation markers, the count of extra bytes and the overflow flag.
    typedef struct packed {
        logic                too_wide;
        logic [LEN_W-1:0]    extra;
        logic [SPREAD_W-1:0] spread;
    } t_layout;

endpackage
`default_nettype wire

// ----- hw/rtl/pve_layout.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pve_layout
// Spreads a code word into 6-bit groups with continuation markers and
// counts the extra bytes the encoding needs.
// ----------------------------------------------------------------------------
module pve_layout (
    input  wire logic [pve_pkg::WORD_W-1:0] i_word,
    output pve_pkg::t_layout                o_layout
);
    import pve_pkg::*;

    logic [POS_W-1:0] l_low;

    assign l_low = i_word[POS_W-1:0];

    always_comb begin
        o_layout          = '0;
        o_layout.too_wide = |i_word[WORD_W-1:POS_W];

        for (int g = 0; g < GROUPS; g++) begin
            for (int b = 0; b < GROUP_BITS; b++) begin
                o_layout.spread[8*g + b] = l_low[GROUP_BITS*g + b];
            end
        end

        // A group is followed by the '10' marker when a later group holds bits.
        for (int g = 0; g < GROUPS - 1; g++) begin
            o_layout.spread[8*g + 7] = |(l_low >> (GROUP_BITS * (g + 1)));
        end

        // One extra byte for each length threshold the word reaches.
        for (int k = 0; k < MAX_EXTRA; k++) begin
            o_layout.extra = o_layout.extra
                + {2'b00, |(l_low >> (ONE_BYTE_LIMIT - 1 + EXTRA_STEP * k))};
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/posting_varint_encoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// posting_varint_encoder
// Path: a word accepted at a rising edge is registered in stage 1, then in
// stage 2, one register stage per step, and is offered from stage 3.
// Throughput: one posting per cycle while the output is not stalled, set by
// the three-stage pipeline; a stall on the output holds stage 3 and each
// occupied stage with no empty stage after it, while words behind move up.
// Reset: synchronous, active low; clears the valid bits of all stages.
// ----------------------------------------------------------------------------
//
// Stage 1 forms the code word from the posting kind. Stage 2 places the word
// in 6-bit groups with '10' continuation markers and counts the extra bytes.
// Stage 3 adds the leading-ones prefix to the last byte and is the output
// register. Each stage advances when it is empty or the stage after it moves,
// so a full pipeline still takes a new word in the cycle the output drains.
module posting_varint_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] action, [37:2] position_value, [39:38] style, [47:40] document_index
    input  wire logic [pve_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [55:0] encoded_bits, [58:56] byte_length, [63:59] zero
    output logic [pve_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] too_wide
    output logic             m_axis_tuser
);
    import pve_pkg::*;

    // Input fields.
    t_action            l_action;
    logic [POS_W-1:0]   l_pos;
    logic [STYLE_W-1:0] l_style;
    logic [DOC_W-1:0]   l_doc;

    assign l_action = t_action'(s_axis_tdata[ACTION_W-1:0]);
    assign l_pos    = s_axis_tdata[ACTION_W+POS_W-1:ACTION_W];
    assign l_style  = s_axis_tdata[ACTION_W+POS_W+STYLE_W-1:ACTION_W+POS_W];
    assign l_doc    = s_axis_tdata[IN_DATA_W-1:ACTION_W+POS_W+STYLE_W];

    // Stage registers.
    logic                r_v1, r_v2, r_v3;
    logic [WORD_W-1:0]   r_word, n_word;
    t_layout             r_lay, n_lay;
    logic [ENC_W-1:0]    r_enc, n_enc;
    logic [LEN_W-1:0]    r_len, n_len;
    logic                r_wide;

    logic l_mv1, l_mv2, l_mv3;

    // A stage may load when it is empty or its content moves on.
    assign l_mv3 = !r_v3 || m_axis_tready;
    assign l_mv2 = !r_v2 || l_mv3;
    assign l_mv1 = !r_v1 || l_mv2;

    assign s_axis_tready = l_mv1;

    // Stage 1: code word. Bit 1 of the action selects the end-of-document
    // form, so the unused code behaves as an end of document.
    always_comb begin
        case (l_action)
            ACT_TITLE: n_word = {{DOC_W{1'b0}}, l_pos};
            ACT_BODY:  n_word = {{(DOC_W-STYLE_W){1'b0}}, l_pos, l_style};
            default:   n_word = {l_pos, l_doc};
        endcase
    end

    // Stage 2: group layout.
    pve_layout u_layout (
        .i_word   (r_word),
        .o_layout (n_lay)
    );

    // Stage 3: the last byte carries extra+1 ones at its top.
    logic [7:0] l_top;

    always_comb begin
        l_top = 8'(8'hFF << (3'd7 - r_lay.extra));
        n_enc = {{(ENC_W-SPREAD_W){1'b0}}, r_lay.spread}
              | (ENC_W'(l_top) << {r_lay.extra, 3'b000});
        n_len = r_lay.extra + 3'd1;
        if (r_lay.too_wide) begin
            n_enc = '0;
            n_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (l_mv1) r_v1 <= s_axis_tvalid;
            if (l_mv2) r_v2 <= r_v1;
            if (l_mv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_mv1) r_word <= n_word;
        if (l_mv2) r_lay  <= n_lay;
        if (l_mv3) begin
            r_enc  <= n_enc;
            r_len  <= n_len;
            r_wide <= r_lay.too_wide;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{(OUT_DATA_W-ENC_W-LEN_W){1'b0}}, r_len, r_enc};
    assign m_axis_tuser  = r_wide;

endmodule
`default_nettype wire

// ----- hw/rtl/pve_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pve_checker
// Port-level checks of the posting varint encoder, bound to the top level.
// ----------------------------------------------------------------------------
module pve_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [pve_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [pve_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    import pve_pkg::*;

    logic [ENC_W-1:0] l_enc;
    logic [LEN_W-1:0] l_len;
    logic [5:0]       l_top_idx;
    logic [ENC_W-1:0] l_above;

    assign l_enc     = m_axis_tdata[ENC_W-1:0];
    assign l_len     = m_axis_tdata[ENC_W+LEN_W-1:ENC_W];
    assign l_top_idx = {l_len, 3'b000} - 6'd1;
    assign l_above   = l_enc >> {l_len, 3'b000};

    // An overflowing word gives no encoding at all.
    a_wide_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> l_enc == '0 && l_len == '0)
        else $error("too_wide result carries encoded data");

    // A normal result ends with a byte whose top bit is set.
    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> l_len != '0 && l_enc[l_top_idx])
        else $error("last encoded byte lacks its top bit");

    // Nothing is encoded past the reported length.
    a_no_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser && l_len != 3'd7 |-> l_above == '0)
        else $error("encoded bits beyond byte_length");

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

endmodule

bind posting_varint_encoder pve_checker u_pve_checker (.*);
`default_nettype wire
